/* src/cdcacm_dp_pkg.sv */
// Package for the CDC-ACM configuration descriptor parser.
// Holds the descriptor codes, the field limits and the parse state type.
// It depends on nothing else.
`timescale 1ns / 1ps

package cdcacm_dp_pkg;

	// Descriptor type codes.
	localparam logic [7:0] TYPE_INTERFACE = 8'h04;
	localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;

	// Interface class and subclass codes.
	localparam logic [7:0] CLASS_COMM   = 8'h02;
	localparam logic [7:0] SUBCLASS_ACM = 8'h02;
	localparam logic [7:0] CLASS_DATA   = 8'h0a;

	// Endpoint attribute and address fields.
	localparam logic [1:0] XFER_BULK  = 2'b10;
	localparam int         DIR_IN_BIT = 7;

	// Smallest descriptor lengths that carry every field used.
	localparam logic [7:0] MIN_DESC_LEN  = 8'd2;
	localparam logic [7:0] IFACE_MIN_LEN = 8'd8;
	localparam logic [7:0] EP_MIN_LEN    = 8'd7;

	// Byte offsets at which descriptor fields are captured or acted on.
	localparam logic [7:0] OFF_LENGTH    = 8'd0;
	localparam logic [7:0] OFF_TYPE      = 8'd1;
	localparam logic [7:0] OFF_FIELD_LO  = 8'd2;
	localparam logic [7:0] OFF_FIELD_HI  = 8'd6;
	localparam logic [7:0] OFF_EP_TAKE   = 8'd6;
	localparam logic [7:0] OFF_IF_TAKE   = 8'd7;

	// Index of each field byte (descriptor offset minus two).
	localparam int FLD_IF_NUMBER = 0;
	localparam int FLD_IF_CLASS  = 3;
	localparam int FLD_IF_SUB    = 4;
	localparam int FLD_EP_ADDR   = 0;
	localparam int FLD_EP_ATTR   = 1;
	localparam int FLD_EP_MPS    = 2;

	typedef struct packed {
		logic [7:0]      off;
		logic [7:0]      len;
		logic [7:0]      dtype;
		logic [4:0][7:0] fld;
		logic            comm_seen;
		logic [7:0]      comm_num;
		logic            data_iface;
		logic            have_in;
		logic            have_out;
		logic [3:0]      in_ep;
		logic [7:0]      in_mps;
		logic [3:0]      out_ep;
		logic [7:0]      out_mps;
		logic            stopped;
	} parse_state_t;

endpackage

/* src/cdc_acm_descriptor_parser.sv */
// Top level of the CDC-ACM configuration descriptor parser.
// Uses cdcacm_dp_pkg for descriptor codes and the parse state type.
// Contains the input register, the parse logic and the result register.
`timescale 1ns / 1ps

// The parser takes one byte of a USB configuration descriptor set per item
// and returns one result item when the byte marked final_byte has been
// processed. It accepts one byte every clock cycle unless a final byte is
// held in the input register; a final byte passes through the input
// register, and its result is loaded into the result register when that
// byte moves on, so out_valid rises once the final byte leaves the input
// register. A result that waits to be taken stalls only a later final byte:
// plain bytes keep flowing through the input register into the parse state
// while the result register is full, and the byte channel stalls only once
// a final byte sits in the input register. When found is low, every other
// result field reads zero. After each final byte the parse state returns to
// its reset value, so a new descriptor set may follow immediately. A length
// byte below two stops the parse until the final byte; a descriptor too
// short for its fields, or cut off before its deciding offset, is ignored.
module cdc_acm_descriptor_parser (
	input  logic       clk,
	input  logic       arst_n,
	// Byte channel.
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	// Result channel.
	output logic       out_valid,
	input  logic       out_ready,
	output logic       found,
	output logic [7:0] comm_interface,
	output logic [3:0] in_endpoint,
	output logic [7:0] in_max_packet,
	output logic [3:0] out_endpoint,
	output logic [7:0] out_max_packet
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       final_s1;

	// Parse state and its next value.
	cdcacm_dp_pkg::parse_state_t st_q;
	cdcacm_dp_pkg::parse_state_t st_d;

	logic       advance;
	logic       stop_now;
	logic [7:0] len_v;
	logic [7:0] type_v;
	logic [7:0] off_inc;
	logic [2:0] fld_idx;
	logic       found_d;

	// The byte in the input register moves on unless it is a final byte and
	// the result register still holds a result that has not been taken.
	assign advance  = valid_s1 && (!final_s1 || !out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= data_byte;
			final_s1 <= final_byte;
		end
	end

	// Parse one byte. The field bytes consulted at the deciding offsets were
	// all captured by earlier bytes of the same descriptor.
	always_comb begin
		st_d     = st_q;
		stop_now = 1'b0;
		len_v    = (st_q.off == cdcacm_dp_pkg::OFF_LENGTH) ? data_s1 : st_q.len;
		type_v   = (st_q.off == cdcacm_dp_pkg::OFF_TYPE) ? data_s1 : st_q.dtype;
		off_inc  = st_q.off + 8'd1;
		fld_idx  = st_q.off[2:0] - 3'd2;

		if (!st_q.stopped) begin
			if (st_q.off == cdcacm_dp_pkg::OFF_LENGTH) begin
				st_d.len = data_s1;
				if (data_s1 < cdcacm_dp_pkg::MIN_DESC_LEN) begin
					stop_now     = 1'b1;
					st_d.stopped = 1'b1;
				end
			end
			if (st_q.off == cdcacm_dp_pkg::OFF_TYPE) begin
				st_d.dtype = data_s1;
			end
			if (st_q.off >= cdcacm_dp_pkg::OFF_FIELD_LO &&
			    st_q.off <= cdcacm_dp_pkg::OFF_FIELD_HI) begin
				st_d.fld[fld_idx] = data_s1;
			end

			if (!stop_now) begin
				// Endpoint descriptor: first bulk IN and first bulk OUT inside
				// a data interface.
				if (st_q.off == cdcacm_dp_pkg::OFF_EP_TAKE &&
				    type_v == cdcacm_dp_pkg::TYPE_ENDPOINT &&
				    len_v >= cdcacm_dp_pkg::EP_MIN_LEN &&
				    st_q.data_iface &&
				    st_q.fld[cdcacm_dp_pkg::FLD_EP_ATTR][1:0] ==
				    cdcacm_dp_pkg::XFER_BULK) begin
					if (st_q.fld[cdcacm_dp_pkg::FLD_EP_ADDR][cdcacm_dp_pkg::DIR_IN_BIT]) begin
						if (!st_q.have_in) begin
							st_d.have_in = 1'b1;
							st_d.in_ep   = st_q.fld[cdcacm_dp_pkg::FLD_EP_ADDR][3:0];
							st_d.in_mps  = st_q.fld[cdcacm_dp_pkg::FLD_EP_MPS];
						end
					end else begin
						if (!st_q.have_out) begin
							st_d.have_out = 1'b1;
							st_d.out_ep   = st_q.fld[cdcacm_dp_pkg::FLD_EP_ADDR][3:0];
							st_d.out_mps  = st_q.fld[cdcacm_dp_pkg::FLD_EP_MPS];
						end
					end
				end

				// Interface descriptor: opens or closes a data interface, and
				// the first ACM communications interface gives its number.
				if (st_q.off == cdcacm_dp_pkg::OFF_IF_TAKE &&
				    type_v == cdcacm_dp_pkg::TYPE_INTERFACE &&
				    len_v >= cdcacm_dp_pkg::IFACE_MIN_LEN) begin
					st_d.data_iface = (st_q.fld[cdcacm_dp_pkg::FLD_IF_CLASS] ==
					                   cdcacm_dp_pkg::CLASS_DATA);
					if (st_q.fld[cdcacm_dp_pkg::FLD_IF_CLASS] == cdcacm_dp_pkg::CLASS_COMM &&
					    st_q.fld[cdcacm_dp_pkg::FLD_IF_SUB] == cdcacm_dp_pkg::SUBCLASS_ACM &&
					    !st_q.comm_seen) begin
						st_d.comm_seen = 1'b1;
						st_d.comm_num  = st_q.fld[cdcacm_dp_pkg::FLD_IF_NUMBER];
					end
				end

				// The offset never reaches the length, so the increment cannot
				// wrap.
				st_d.off = (off_inc >= len_v) ? 8'd0 : off_inc;
			end
		end

		found_d = st_d.comm_seen && st_d.have_in && st_d.have_out;
	end

	// Parse state register. A final byte returns the parser to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			if (final_s1) begin
				st_q <= '0;
			end else begin
				st_q <= st_d;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && final_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			found          <= found_d;
			comm_interface <= found_d ? st_d.comm_num : 8'd0;
			in_endpoint    <= found_d ? st_d.in_ep : 4'd0;
			in_max_packet  <= found_d ? st_d.in_mps : 8'd0;
			out_endpoint   <= found_d ? st_d.out_ep : 4'd0;
			out_max_packet <= found_d ? st_d.out_mps : 8'd0;
		end
	end

endmodule

/* src/cdcacm_dp_checker.sv */
// Port-level checker for the CDC-ACM configuration descriptor parser.
// Depends only on the top level's ports; bound to cdc_acm_descriptor_parser below.
`timescale 1ns / 1ps

module cdcacm_dp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] data_byte,
	input logic       final_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic       found,
	input logic [7:0] comm_interface,
	input logic [3:0] in_endpoint,
	input logic [7:0] in_max_packet,
	input logic [3:0] out_endpoint,
	input logic [7:0] out_max_packet
);

	// A byte offered and not yet taken stays offered and unchanged.
	a_byte_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(data_byte) &&
		$stable(final_byte))
		else $error("offered byte changed before it was taken");

	// A result that reports nothing found carries all-zero fields.
	a_zero_when_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> comm_interface == 8'd0 && in_endpoint == 4'd0 &&
		in_max_packet == 8'd0 && out_endpoint == 4'd0 && out_max_packet == 8'd0)
		else $error("result fields not zero while found is low");

	// With the result register empty, the parser must take a byte.
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("byte channel stalled with no result pending");

	// A stalled result stays put.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) &&
		$stable(comm_interface) && $stable(in_endpoint) && $stable(in_max_packet) &&
		$stable(out_endpoint) && $stable(out_max_packet))
		else $error("stalled result changed");

endmodule

bind cdc_acm_descriptor_parser cdcacm_dp_checker u_cdcacm_dp_checker (.*);
